[design/chq_pkg.sv]
package chq_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int StackDepth = 2 * MaxPoints + 2;
  localparam int StkW = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_LOCATE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LOC_OUTSIDE  = 2'd0,
    LOC_BOUNDARY = 2'd1,
    LOC_INSIDE   = 2'd2,
    LOC_NO_HULL  = 2'd3
  } loc_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [6:0]         hull_size;
    logic [33:0]        twice_area;
    logic [1:0]         location;
    logic               overflowed;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pt_t;

  // exact cross product of (a-o) x (b-o); 17-bit differences, 36-bit products
  function automatic logic signed [35:0] cross3(pt_t o, pt_t a, pt_t b);
    logic signed [16:0] ax, ay, bx, by;
    logic signed [35:0] p1, p2;
    ax = 17'(a.x) - 17'(o.x);
    ay = 17'(a.y) - 17'(o.y);
    bx = 17'(b.x) - 17'(o.x);
    by = 17'(b.y) - 17'(o.y);
    p1 = 36'(ax * by);
    p2 = 36'(ay * bx);
    return p1 - p2;
  endfunction

  function automatic logic pt_less(pt_t a, pt_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

[design/convex_hull_with_point_query.sv]
// convex hull store with point location
// input channel (in_valid/in_stall/in_data) carries requests: add a point,
// build the hull, locate a point, or clear everything. output channel
// (out_valid/out_stall/out_data) carries results, last marks the final
// result of a request.
// one request is worked at a time; in_stall stays high until the final
// result of the current request sits in the output register.
// add and clear return nothing.
// a build sorts the store by insertion sort held in a point memory (one
// read per cycle), then runs a dedup pass, the two chain passes with their
// pushes and pops, a copy of the stack to the hull, a fan area pass and
// the output of each vertex.
// a locate takes the area pass, a binary search, the final tests and the
// loading of the result.
// all accesses go through synchronous memories with registered read
// data; the sequencer waits for read data before using it.
// reset clears counts and the drop flag; no memory clearing pass is needed.
// when out_stall is high while a result is valid, the result register holds and the sequencer waits.
module convex_hull_with_point_query (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  chq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chq_pkg::out_item_t out_data
);
  import chq_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_SRTI  = 23'h000002, // start outer insertion step: read i
    S_SRTV  = 23'h000004, // latch v, read j-1
    S_SRTC  = 23'h000008, // compare v with entry j-1
    S_DEDR  = 23'h000010, // dedup: read i
    S_DEDC  = 23'h000020,
    S_CHR   = 23'h000040, // chain: read point i
    S_CHT   = 23'h000080, // read stack top entries
    S_CHT2  = 23'h000100,
    S_CHC   = 23'h000200,
    S_HCP   = 23'h000400, // copy stack to hull
    S_HCPW  = 23'h000800,
    S_AR0   = 23'h001000, // area: read h0
    S_ARR   = 23'h002000,
    S_ARR2  = 23'h004000,
    S_ARC   = 23'h008000,
    S_EMIT  = 23'h010000,
    S_EMW   = 23'h020000,
    S_LBS   = 23'h040000, // locate binary search read
    S_LBC   = 23'h080000,
    S_LFR   = 23'h100000, // locate final reads
    S_LFC   = 23'h200000,
    S_OUT   = 23'h400000
  } state_t;

  state_t state;

  // point memory
  pt_t pmem [MaxPoints];
  logic [IdxW-1:0] p_raddr, p_waddr;
  logic p_we;
  pt_t p_wdata, p_rdata;
  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  // hull memory
  pt_t hmem [MaxPoints];
  logic [IdxW-1:0] h_raddr, h_waddr;
  logic h_we;
  pt_t h_wdata, h_rdata;
  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    h_rdata <= hmem[h_raddr];
  end

  // chain stack memory
  pt_t smem [StackDepth];
  logic [StkW-1:0] s_raddr, s_waddr;
  logic s_we;
  pt_t s_wdata, s_rdata;
  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr[StkW-1:0]] <= s_wdata;
    s_rdata <= smem[s_raddr];
  end

  logic [CntW-1:0] point_count, hull_count;
  logic            drop_flag;

  logic [CntW-1:0] i, j, m, lo, hi, md;
  logic [StkW-1:0] k, t;
  logic            pass2;
  logic [2:0]      ph;
  pt_t             v, a, b, c, h0, q;
  logic signed [35:0] cr;
  logic signed [39:0] area_sum;
  logic [33:0]     area;
  logic            do_locate;
  logic [1:0]      loc;
  logic signed [37:0] s2;
  logic signed [35:0] s1;

  out_item_t obuf;
  logic      ovalid;
  assign out_valid = ovalid;
  assign out_data  = obuf;
  assign in_stall  = (state != S_IDLE);

  function automatic logic signed [35:0] abs36(logic signed [35:0] x);
    return x < 0 ? -x : x;
  endfunction

  always_comb begin
    p_raddr = i[IdxW-1:0];
    h_raddr = i[IdxW-1:0];
    s_raddr = k;
    unique case (state)
      S_SRTV, S_SRTC: p_raddr = IdxW'(j - 1'b1);
      S_CHT:   s_raddr = StkW'(k - 2'd2);
      S_CHT2:  s_raddr = StkW'(k - 1'b1);
      S_HCP, S_HCPW: s_raddr = StkW'(i);
      S_LBS:   h_raddr = md[IdxW-1:0];
      S_LFR: begin
        unique case (ph)
          3'd0:    h_raddr = IdxW'(lo - 1'b1);
          3'd1:    h_raddr = lo[IdxW-1:0];
          3'd2:    h_raddr = hi[IdxW-1:0];
          default: h_raddr = (hi + 1'b1 == hull_count) ? '0 : IdxW'(hi + 1'b1);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    logic p_we_next, h_we_next, s_we_next, ovalid_next;
    p_we_next = 1'b0;
    h_we_next = 1'b0;
    s_we_next = 1'b0;
    ovalid_next = ovalid && out_stall;
    if (rst) begin
      state <= S_IDLE;
      point_count <= '0;
      hull_count <= '0;
      drop_flag <= 1'b0;
      ovalid_next = 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q <= '{x: in_data.px, y: in_data.py};
            unique case (req_t'(in_data.req_type))
              REQ_ADD: begin
                if (point_count < CntW'(MaxPoints)) begin
                  p_we_next = 1'b1;
                  p_waddr <= point_count[IdxW-1:0];
                  p_wdata <= '{x: in_data.px, y: in_data.py};
                  point_count <= point_count + 1'b1;
                end else begin
                  drop_flag <= 1'b1;
                end
              end
              REQ_CLEAR: begin
                point_count <= '0;
                hull_count <= '0;
                drop_flag <= 1'b0;
              end
              REQ_BUILD: begin
                i <= CntW'(1);
                state <= S_SRTI;
              end
              default: begin
                do_locate <= 1'b1;
                i <= '0;
                state <= S_AR0;
              end
            endcase
          end
        end
        S_SRTI: begin
          if (i >= point_count) begin
            i <= '0;
            m <= '0;
            state <= S_DEDR;
          end else begin
            j <= i;
            state <= S_SRTV;
          end
        end
        S_SRTV: begin
          // entry i is picked up once, later passes only shift
          if (j == i) v <= p_rdata;
          state <= S_SRTC;
        end
        S_SRTC: begin
          if (j != 0 && pt_less(v, p_rdata)) begin
            p_we_next = 1'b1;
            p_waddr <= j[IdxW-1:0];
            p_wdata <= p_rdata;
            j <= j - 1'b1;
            state <= S_SRTV;
            v <= v;
          end else begin
            p_we_next = 1'b1;
            p_waddr <= j[IdxW-1:0];
            p_wdata <= v;
            i <= i + 1'b1;
            state <= S_SRTI;
          end
        end
        S_DEDR: begin
          if (i >= point_count) begin
            if (m <= CntW'(1)) begin
              hull_count <= m;
              if (m == CntW'(1)) begin
                h_we_next = 1'b1;
                h_waddr <= '0;
                h_wdata <= v;
              end
              do_locate <= 1'b0;
              i <= '0;
              state <= S_AR0;
            end else begin
              i <= '0;
              k <= '0;
              pass2 <= 1'b0;
              state <= S_CHR;
            end
          end else begin
            state <= S_DEDC;
          end
        end
        S_DEDC: begin
          if (m == 0 || p_rdata != v) begin
            p_we_next = 1'b1;
            p_waddr <= m[IdxW-1:0];
            p_wdata <= p_rdata;
            m <= m + 1'b1;
            v <= p_rdata;
          end
          i <= i + 1'b1;
          state <= S_DEDR;
        end
        S_CHR: begin
          // p_raddr = i already issued
          state <= S_CHT;
        end
        S_CHT: begin
          c <= p_rdata;
          state <= S_CHT2;
        end
        S_CHT2: begin
          a <= s_rdata;
          state <= S_CHC;
          ph <= 3'd0;
        end
        S_CHC: begin
          if (ph == 3'd0) begin
            b <= s_rdata;
            ph <= 3'd1;
          end else if ((pass2 ? (k >= t) : (k >= StkW'(2))) &&
                       cross3(a, b, c) <= 0) begin
            k <= k - 1'b1;
            state <= S_CHT;
          end else begin
            s_we_next = 1'b1;
            s_waddr <= k;
            s_wdata <= c;
            k <= k + 1'b1;
            if (!pass2) begin
              if (i + 1'b1 == m) begin
                pass2 <= 1'b1;
                t <= k + 2'd2;
                if (m >= CntW'(2)) begin
                  i <= m - 2'd2;
                  state <= S_CHR;
                end
              end else begin
                i <= i + 1'b1;
                state <= S_CHR;
              end
            end else if (i == 0) begin
              hull_count <= CntW'(k);
              i <= '0;
              state <= S_HCP;
            end else begin
              i <= i - 1'b1;
              state <= S_CHR;
            end
          end
        end
        S_HCP: begin
          if (i >= hull_count) begin
            i <= '0;
            do_locate <= 1'b0;
            state <= S_AR0;
          end else begin
            state <= S_HCPW;
          end
        end
        S_HCPW: begin
          h_we_next = 1'b1;
          h_waddr <= i[IdxW-1:0];
          h_wdata <= s_rdata;
          i <= i + 1'b1;
          state <= S_HCP;
        end
        S_AR0: begin
          // hull reads start after any write of the previous cycle
          area_sum <= '0;
          i <= '0;
          ph <= 3'd0;
          state <= S_ARR;
        end
        S_ARR: begin
          state <= S_ARR2;
        end
        S_ARR2: begin
          if (i == 0) h0 <= h_rdata;
          a <= b;
          b <= h_rdata;
          state <= S_ARC;
        end
        S_ARC: begin
          if (i >= CntW'(2))
            area_sum <= area_sum + 40'(cross3(h0, a, b));
          if (i + 1'b1 >= hull_count) begin
            area <= 34'(area_sum + ((i >= CntW'(2)) ? 40'(cross3(h0, a, b)) : 40'sd0) < 0 ?
              -(area_sum + ((i >= CntW'(2)) ? 40'(cross3(h0, a, b)) : 40'sd0)) :
              (area_sum + ((i >= CntW'(2)) ? 40'(cross3(h0, a, b)) : 40'sd0)));
            i <= '0;
            if (!do_locate) begin
              state <= S_EMIT;
            end else if (hull_count < CntW'(3)) begin
              loc <= LOC_NO_HULL;
              state <= S_OUT;
            end else begin
              lo <= CntW'(1);
              hi <= hull_count - 1'b1;
              state <= S_LBS;
              md <= (CntW'(1) + hull_count - 1'b1) >> 1;
            end
          end else begin
            i <= i + 1'b1;
            state <= S_ARR;
          end
        end
        S_EMIT: begin
          if (!ovalid || !out_stall) state <= S_EMW;
        end
        S_EMW: begin
          if (!ovalid || !out_stall) begin
            ovalid_next = 1'b1;
            obuf.hull_size <= 7'(hull_count);
            obuf.twice_area <= area;
            obuf.location <= LOC_OUTSIDE;
            obuf.overflowed <= drop_flag;
            if (hull_count == 0) begin
              obuf.result_kind <= KIND_EMPTY;
              obuf.vertex_x <= '0;
              obuf.vertex_y <= '0;
              obuf.last <= 1'b1;
              state <= S_IDLE;
            end else begin
              obuf.result_kind <= KIND_VERTEX;
              obuf.vertex_x <= h_rdata.x;
              obuf.vertex_y <= h_rdata.y;
              obuf.last <= (i + 1'b1 == hull_count);
              i <= i + 1'b1;
              state <= (i + 1'b1 == hull_count) ? S_IDLE : S_EMIT;
            end
          end
        end
        S_LBS: begin
          if (hi - lo > CntW'(1)) state <= S_LBC;
          else begin
            ph <= 3'd0;
            state <= S_LFR;
          end
        end
        S_LBC: begin
          if (cross3(h0, h_rdata, q) > 0) begin
            lo <= md;
            md <= (md + hi) >> 1;
          end else begin
            hi <= md;
            md <= (lo + md) >> 1;
          end
          state <= S_LBS;
        end
        S_LFR: begin
          state <= S_LFC;
        end
        S_LFC: begin
          unique case (ph)
            3'd0: begin
              v <= h_rdata;
              ph <= 3'd1;
              state <= S_LFR;
            end
            3'd1: begin
              a <= h_rdata;
              ph <= 3'd2;
              state <= S_LFR;
            end
            3'd2: begin
              b <= h_rdata;
              ph <= 3'd3;
              state <= S_LFR;
            end
            3'd3: begin
              c <= h_rdata;
              s1 <= abs36(cross3(h0, a, b));
              s2 <= 38'(abs36(cross3(q, h0, a))) + 38'(abs36(cross3(q, a, b))) +
                    38'(abs36(cross3(q, b, h0)));
              ph <= 3'd4;
            end
            default: begin
              if (38'(s1) != s2) loc <= LOC_OUTSIDE;
              else if (cross3(v, a, q) == 0 || cross3(a, b, q) == 0 ||
                       cross3(c, b, q) == 0) loc <= LOC_BOUNDARY;
              else loc <= LOC_INSIDE;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!ovalid || !out_stall) begin
            ovalid_next = 1'b1;
            obuf.result_kind <= KIND_QUERY;
            obuf.vertex_x <= '0;
            obuf.vertex_y <= '0;
            obuf.hull_size <= 7'(hull_count);
            obuf.twice_area <= area;
            obuf.location <= loc;
            obuf.overflowed <= drop_flag;
            obuf.last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    p_we <= p_we_next;
    h_we <= h_we_next;
    s_we <= s_we_next;
    ovalid <= ovalid_next;
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("request accepted mid result stream");
  a_count: assert property (@(posedge clk) disable iff (rst)
    point_count <= CntW'(MaxPoints) && hull_count <= CntW'(MaxPoints))
    else $error("count beyond capacity");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
`endif

endmodule
